// ----- src/simon64_pkg.sv -----
package simon64_pkg;

    localparam int WordW     = 32;
    localparam int MaxRounds = 44;
    localparam int Rounds96  = 42;
    localparam int Rounds128 = 44;
    localparam int AddrW     = $clog2(MaxRounds);
    localparam int CntW      = $clog2(MaxRounds + 1);
    localparam int KeyWords  = 4;
    localparam int KeyIdxW   = $clog2(KeyWords);
    localparam int SeqLen    = 62;
    localparam int SeqIdxW   = $clog2(SeqLen);

    localparam logic [WordW-1:0] KsConst = 32'hffff_fffc;

    // Element 0 of each sequence is the leftmost bit
    localparam logic [0:SeqLen-1] Z2 =
        62'b1010111101_1100000011_0100100110_0_0101000010_0011111100_1011011001_1;
    localparam logic [0:SeqLen-1] Z3 =
        62'b1101101110_1011000110_0101111000_0_0010010001_0100111001_1010000111_1;

    localparam int CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] CfgKeyWord0 = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgKeyWord1 = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgKeyWord2 = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgKeyWord3 = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgKeySize  = 3'd4;

    localparam logic FuncEncrypt = 1'b0;
    localparam logic FuncDecrypt = 1'b1;

    typedef struct packed {
        logic             func;
        logic [WordW-1:0] block_low;
        logic [WordW-1:0] block_high;
    } in_item_t;

    typedef struct packed {
        logic [WordW-1:0] result_low;
        logic [WordW-1:0] result_high;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_LOAD,
        ST_ROUND
    } state_t;

endpackage

// ----- src/simon64_ram.sv -----
module simon64_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 44
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/simon64_block_cipher_engine.sv -----
// Simon 64/96 and 64/128 block cipher, one round per clock.
// Configuration: write key words 0..3 and the key size (index 4, 0 = 96-bit,
// 1 = 128-bit) through cfg_we/cfg_index/cfg_data while busy is low. Any write
// to those registers marks the round keys stale.
// Input: an item is taken at a clock edge with start high and busy low; func
// selects encrypt (0) or decrypt (1), block_high/block_low hold words x/y.
// Key schedule: the first item after reset or a key write expands the round
// keys into the key RAM first, one key per cycle, then prefetches the first
// round key in the load state.
// Sequence: with keys in place, the transfer goes straight to the round state;
// done rises after the last of R rounds, R being 42 or 44, and the result is
// taken while done is high. Otherwise the expansion and the load state come first.
// Items: the engine works on one item at a time; busy drops in the cycle done is
// high, so the next start can be taken there. The round loop is limited by
// the single key RAM read port, one round key per cycle.
// Output: result is valid for exactly one cycle while done is high; the
// receiver cannot stall and must take it then.
// Reset: key words clear to zero, key size goes to 128-bit, round keys are
// stale, and no result is pending.
module simon64_block_cipher_engine (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  simon64_pkg::in_item_t             item,
    output logic                              done,
    output simon64_pkg::out_item_t            result,
    input  logic                              cfg_we,
    input  logic [simon64_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [simon64_pkg::WordW-1:0]     cfg_data
);

    import simon64_pkg::*;

    function automatic logic [WordW-1:0] rol(input logic [WordW-1:0] v, input int s);
        return (v << s) | (v >> (WordW - s));
    endfunction

    function automatic logic [WordW-1:0] ror(input logic [WordW-1:0] v, input int s);
        return (v >> s) | (v << (WordW - s));
    endfunction

    function automatic logic [WordW-1:0] round_f(input logic [WordW-1:0] v);
        return (rol(v, 1) & rol(v, 8)) ^ rol(v, 2);
    endfunction

    state_t            state_reg, state_next;
    logic [AddrW-1:0]  idx_reg, idx_next;
    logic [CntW-1:0]   total_reg, total_next;
    logic              long_key_reg, long_key_next;
    logic              dec_reg, dec_next;
    logic [WordW-1:0]  p_reg, p_next;
    logic [WordW-1:0]  q_reg, q_next;
    logic [WordW-1:0]  win_reg [KeyWords];
    logic [WordW-1:0]  win_next [KeyWords];
    logic [WordW-1:0]  key_reg [KeyWords];
    logic              key_size_reg;
    logic              keys_ready_reg;
    logic              done_reg, done_next;
    out_item_t         result_reg, result_next;

    logic              ram_we;
    logic [AddrW-1:0]  ram_raddr;
    logic [WordW-1:0]  ram_wdata;
    logic [WordW-1:0]  ram_rdata;

    logic [CntW-1:0]    rounds_now;
    logic               last_idx;
    logic               cfg_hit;
    logic [AddrW-1:0]   key_count;
    logic [SeqIdxW-1:0] seq_idx;
    logic               seq_bit;
    logic [WordW-1:0]   tmp_a;
    logic [WordW-1:0]   tmp_b;
    logic [WordW-1:0]   new_key;
    logic [WordW-1:0]   round_out;

    simon64_ram #(
        .WIDTH (WordW),
        .DEPTH (MaxRounds)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rounds_now = key_size_reg ? CntW'(Rounds128) : CntW'(Rounds96);
    assign last_idx   = (idx_reg == AddrW'(total_reg - CntW'(1)));
    assign cfg_hit    = cfg_we && (cfg_index <= CfgKeySize);

    // Key schedule from the window of the last four keys, newest in slot 3
    assign key_count = long_key_reg ? AddrW'(4) : AddrW'(3);
    assign seq_idx   = (idx_reg >= key_count) ? SeqIdxW'(idx_reg - key_count) : '0;
    assign seq_bit   = long_key_reg ? Z3[seq_idx] : Z2[seq_idx];
    assign tmp_a     = ror(win_reg[3], 3) ^ (long_key_reg ? win_reg[1] : '0);
    assign tmp_b     = tmp_a ^ ror(tmp_a, 1);
    assign new_key   = KsConst ^ (long_key_reg ? win_reg[0] : win_reg[1]) ^ tmp_b
                       ^ {{(WordW-1){1'b0}}, seq_bit};
    assign ram_wdata = (idx_reg < key_count) ? key_reg[idx_reg[KeyIdxW-1:0]] : new_key;

    assign round_out = q_reg ^ round_f(p_reg) ^ ram_rdata;

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        total_next    = total_reg;
        long_key_next = long_key_reg;
        dec_next      = dec_reg;
        p_next        = p_reg;
        q_next        = q_reg;
        win_next      = win_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        ram_we        = 1'b0;
        ram_raddr     = '0;

        case (state_reg)
            ST_IDLE:
            begin
                // Prefetch the first round key in case a transfer happens now
                if (item.func == FuncDecrypt)
                begin
                    ram_raddr = AddrW'(rounds_now - CntW'(1));
                end
                if (start)
                begin
                    long_key_next = key_size_reg;
                    total_next    = rounds_now;
                    dec_next      = item.func;
                    idx_next      = '0;
                    // Decrypt runs the forward round on swapped words
                    if (item.func == FuncDecrypt)
                    begin
                        p_next = item.block_low;
                        q_next = item.block_high;
                    end
                    else
                    begin
                        p_next = item.block_high;
                        q_next = item.block_low;
                    end
                    state_next = keys_ready_reg ? ST_ROUND : ST_EXPAND;
                end
            end
            ST_EXPAND:
            begin
                ram_we      = 1'b1;
                win_next[0] = win_reg[1];
                win_next[1] = win_reg[2];
                win_next[2] = win_reg[3];
                win_next[3] = ram_wdata;
                idx_next    = idx_reg + AddrW'(1);
                if (last_idx)
                begin
                    idx_next   = '0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                // Separate cycle so the read never meets the last key write
                if (dec_reg)
                begin
                    ram_raddr = AddrW'(total_reg - CntW'(1));
                end
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                p_next   = round_out;
                q_next   = p_reg;
                idx_next = idx_reg + AddrW'(1);
                if (!last_idx)
                begin
                    ram_raddr = dec_reg ? AddrW'(total_reg - CntW'(2)) - idx_reg
                                        : idx_reg + AddrW'(1);
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                    if (dec_reg)
                    begin
                        result_next.result_low  = round_out;
                        result_next.result_high = p_reg;
                    end
                    else
                    begin
                        result_next.result_low  = p_reg;
                        result_next.result_high = round_out;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            done_reg       <= 1'b0;
            keys_ready_reg <= 1'b0;
            key_size_reg   <= 1'b1;
            for (int i = 0; i < KeyWords; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
            if (state_reg == ST_EXPAND && last_idx)
            begin
                keys_ready_reg <= 1'b1;
            end
            if (cfg_hit)
            begin
                keys_ready_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CfgKeyWord0: key_reg[0]   <= cfg_data;
                    CfgKeyWord1: key_reg[1]   <= cfg_data;
                    CfgKeyWord2: key_reg[2]   <= cfg_data;
                    CfgKeyWord3: key_reg[3]   <= cfg_data;
                    CfgKeySize:  key_size_reg <= cfg_data[0];
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg    <= total_next;
        long_key_reg <= long_key_next;
        dec_reg      <= dec_next;
        p_reg        <= p_next;
        q_reg        <= q_next;
        win_reg      <= win_next;
        result_reg   <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_done_after_round: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_ROUND))
        else $error("result strobe without a final round");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("engine busy while a result is shown");

    a_load_after_expand: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOAD |-> $past(state_reg == ST_EXPAND))
        else $error("key prefetch without a preceding expansion");

    a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROUND |-> CntW'(idx_reg) < total_reg)
        else $error("round index beyond round count");

    a_transfer_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("transfer did not start the engine");
`endif

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

    import simon64_pkg::*;

    localparam int ClkPeriod  = 4;
    localparam int ResetCycles = 12;
    localparam int NumItems   = 1400;
    localparam int TailCycles = 100;
    localparam int MaxPrinted = 40;

    // Indexes past the end of the register list; writes there are ignored
    localparam logic [CfgIdxW-1:0] CfgFirstUnused = CfgIdxW'(CfgKeySize + 1);
    localparam logic [CfgIdxW-1:0] CfgLastUnused  = '1;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    logic                 busy;
    in_item_t             item      = '0;
    logic                 done;
    out_item_t            result;
    logic                 cfg_we    = 1'b0;
    logic [CfgIdxW-1:0]   cfg_index = '0;
    logic [WordW-1:0]     cfg_data  = '0;

    in_item_t  blocks_to_send [$];
    out_item_t expected_blocks [$];

    int errors      = 0;
    int gap_left    = 0;
    int burst_left  = 0;
    bit sender_gaps = 1'b0;

    // Cipher key and expanded schedule as the block should hold them
    logic [WordW-1:0] key_words [KeyWords];
    logic             long_key;
    logic [WordW-1:0] round_keys [MaxRounds];
    bit               keys_valid;

    simon64_block_cipher_engine i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(ClkPeriod / 2) clk = ~clk;

    function automatic logic [WordW-1:0] rotl(logic [WordW-1:0] v, int s);
        return (v << s) | (v >> (WordW - s));
    endfunction

    function automatic logic [WordW-1:0] rotr(logic [WordW-1:0] v, int s);
        return (v >> s) | (v << (WordW - s));
    endfunction

    function automatic logic [WordW-1:0] simon_f(logic [WordW-1:0] x);
        return (rotl(x, 1) & rotl(x, 8)) ^ rotl(x, 2);
    endfunction

    function automatic int num_rounds();
        return long_key ? Rounds128 : Rounds96;
    endfunction

    function automatic void expand_round_keys();
        int               m;
        logic [WordW-1:0] t;
        logic             z;
        m = long_key ? KeyWords : KeyWords - 1;
        for (int i = 0; i < MaxRounds; i++)
            round_keys[i] = '0;
        for (int i = 0; i < m; i++)
            round_keys[i] = key_words[i];
        for (int i = m; i < num_rounds(); i++) begin
            t = rotr(round_keys[i-1], 3);
            if (long_key)
                t ^= round_keys[i-3];
            t ^= rotr(t, 1);
            z = long_key ? Z3[(i - m) % SeqLen] : Z2[(i - m) % SeqLen];
            round_keys[i] = KsConst ^ round_keys[i-m] ^ t ^ WordW'(z);
        end
        keys_valid = 1'b1;
    endfunction

    function automatic out_item_t simon_crypt(in_item_t blk);
        logic [WordW-1:0] x;
        logic [WordW-1:0] y;
        int               n;
        out_item_t        r;
        if (!keys_valid)
            expand_round_keys();
        n = num_rounds();
        y = blk.block_low;
        x = blk.block_high;
        if (blk.func == FuncEncrypt) begin
            for (int i = 0; i + 1 < n; i += 2) begin
                y ^= round_keys[i] ^ simon_f(x);
                x ^= round_keys[i+1] ^ simon_f(y);
            end
        end else begin
            for (int i = n; i >= 2; i -= 2) begin
                x ^= round_keys[i-1] ^ simon_f(y);
                y ^= round_keys[i-2] ^ simon_f(x);
            end
        end
        r.result_low  = y;
        r.result_high = x;
        return r;
    endfunction

    function automatic logic [WordW-1:0] pick_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [WordW-1:0] got, logic [WordW-1:0] want);
        if (errors < MaxPrinted)
            $display("ERROR at %0t: %s got %08h want %08h", $time, what, got, want);
        errors++;
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [WordW-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CfgKeyWord0: key_words[0] = data;
            CfgKeyWord1: key_words[1] = data;
            CfgKeyWord2: key_words[2] = data;
            CfgKeyWord3: key_words[3] = data;
            CfgKeySize:  long_key     = data[0];
            default:     ;
        endcase
        if (idx <= CfgKeySize)
            keys_valid = 1'b0;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_key(logic [WordW-1:0] w0, logic [WordW-1:0] w1, logic [WordW-1:0] w2,
                            logic [WordW-1:0] w3, logic [WordW-1:0] size_word);
        write_reg(CfgKeyWord0, w0);
        write_reg(CfgKeyWord1, w1);
        write_reg(CfgKeyWord2, w2);
        write_reg(CfgKeyWord3, w3);
        write_reg(CfgKeySize, size_word);
    endtask

    task automatic queue_block(logic func, logic [WordW-1:0] low, logic [WordW-1:0] high);
        in_item_t blk;
        blk.func       = func;
        blk.block_low  = low;
        blk.block_high = high;
        blocks_to_send.push_back(blk);
    endtask

    // Pause the sender until every transfer has gone out and come back
    task automatic drain();
        do
            @(negedge clk);
        while (blocks_to_send.size() != 0 || start || expected_blocks.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start     <= 1'b0;
            item      <= '0;
            gap_left   = 0;
            burst_left = 0;
        end else begin
            if (start && !busy) begin
                expected_blocks.push_back(simon_crypt(item));
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0 && sender_gaps)
                    gap_left = ($urandom_range(3) == 0) ? $urandom_range(120, 50)
                                                        : $urandom_range(40);
            end
            // Slot is empty or its transfer happens at this edge
            if (!start || !busy) begin
                if (gap_left > 0 || blocks_to_send.size() == 0) begin
                    if (gap_left > 0)
                        gap_left--;
                    start <= 1'b0;
                end else begin
                    if (burst_left == 0)
                        burst_left = $urandom_range(8, 1);
                    item  <= blocks_to_send.pop_front();
                    start <= 1'b1;
                end
            end
        end
    end

    always @(posedge clk) begin : result_check
        out_item_t want;
        if (rst_n && done) begin
            if (expected_blocks.size() == 0) begin
                report_mismatch("result with nothing pending, low", result.result_low, '0);
            end else begin
                want = expected_blocks.pop_front();
                if (result.result_low !== want.result_low)
                    report_mismatch("result_low", result.result_low, want.result_low);
                if (result.result_high !== want.result_high)
                    report_mismatch("result_high", result.result_high, want.result_high);
            end
        end
    end

    initial begin : stimulus
        int total;
        int count;
        for (int i = 0; i < KeyWords; i++)
            key_words[i] = '0;
        long_key   = 1'b1;
        keys_valid = 1'b0;

        repeat (ResetCycles) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset key (all zero, 128-bit), extremes of the block words
        for (int f = 0; f < 2; f++) begin
            queue_block(f ? FuncDecrypt : FuncEncrypt, 32'h0000_0000, 32'h0000_0000);
            queue_block(f ? FuncDecrypt : FuncEncrypt, 32'hffff_ffff, 32'hffff_ffff);
            queue_block(f ? FuncDecrypt : FuncEncrypt, 32'haaaa_aaaa, 32'h5555_5555);
            queue_block(f ? FuncDecrypt : FuncEncrypt, 32'h0000_0001, 32'h8000_0000);
        end
        drain();

        // Published 128-bit key and its block, both directions
        load_key(32'h0302_0100, 32'h0b0a_0908, 32'h1312_1110, 32'h1b1a_1918, 32'h1);
        queue_block(FuncEncrypt, 32'h2064_6e75, 32'h656b_696c);
        queue_block(FuncDecrypt, 32'hb9df_a07a, 32'h44c8_fc20);
        drain();

        // 96-bit key; upper bits of the key size word must not matter
        load_key(32'h0302_0100, 32'h0b0a_0908, 32'h1312_1110, 32'hdead_beef, 32'hffff_fffe);
        queue_block(FuncEncrypt, 32'h6e69_6c63, 32'h6f72_2067);
        queue_block(FuncDecrypt, 32'h111a_8fc8, 32'h5ca2_e27f);
        drain();

        // A single key word write forces a new schedule
        write_reg(CfgKeyWord1, 32'hffff_ffff);
        queue_block(FuncEncrypt, 32'h1234_5678, 32'h9abc_def0);
        queue_block(FuncDecrypt, 32'h1234_5678, 32'h9abc_def0);
        drain();

        // Writes past the register list leave the key alone
        for (int idx = CfgFirstUnused; idx <= CfgLastUnused; idx++)
            write_reg(CfgIdxW'(idx), $urandom());
        queue_block(FuncEncrypt, 32'hffff_ffff, 32'h0000_0000);
        queue_block(FuncDecrypt, 32'h0000_0000, 32'hffff_ffff);
        drain();

        load_key('1, '1, '1, '1, 32'h1);
        queue_block(FuncEncrypt, 32'h0000_0000, 32'hffff_ffff);
        queue_block(FuncDecrypt, 32'hffff_ffff, 32'h0000_0000);
        drain();

        load_key('0, '0, '0, '0, 32'h0);
        queue_block(FuncEncrypt, 32'hffff_ffff, 32'hffff_ffff);
        queue_block(FuncDecrypt, 32'h0000_0000, 32'h0000_0000);
        drain();

        total = 0;
        while (total < NumItems) begin
            case ($urandom_range(3))
                0: ;
                1: load_key(pick_word(), pick_word(), pick_word(), pick_word(), $urandom());
                2: begin
                    for (int idx = CfgKeyWord0; idx <= CfgKeySize; idx++)
                        if ($urandom_range(1))
                            write_reg(CfgIdxW'(idx), pick_word());
                end
                default: begin
                    write_reg(CfgIdxW'($urandom_range(CfgLastUnused, CfgFirstUnused)),
                              $urandom());
                    if ($urandom_range(1))
                        write_reg(CfgKeySize, $urandom());
                end
            endcase
            sender_gaps = ($urandom_range(3) != 0);
            count = $urandom_range(120, 20);
            for (int i = 0; i < count; i++)
                queue_block($urandom_range(1) ? FuncDecrypt : FuncEncrypt,
                            pick_word(), pick_word());
            total += count;
            drain();
        end

        repeat (TailCycles) @(negedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #6_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
